// ----- rtl/core/mersenne_twister_generator_core_macros.svh -----
// Assertion macros used by the generator's checker file.
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising edge, held off during reset.
`define MTG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("generator check failed");

// Next-cycle implication, checked on the rising edge, held off during reset.
`define MTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("generator check failed");

`endif

// ----- rtl/core/mtg_pkg.sv -----
// Package: constants, control and status types and the tempering function.
package mtg_pkg;

    localparam int unsigned DEF_STATE_DEPTH   = 624;
    localparam int unsigned DEF_MIDDLE_OFFSET = 397;

    localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    typedef struct packed {
        logic load_seed;
        logic use_default;
        logic seed_step;
        logic rd_pair;
        logic rd_mid;
        logic twist;
    } mtg_ctrl_t;

    typedef struct packed {
        logic unseeded;
        logic seed_last;
    } mtg_status_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- rtl/core/mersenne_twister_generator_core.sv -----
// Top level of the MT19937 word generator: controller plus datapath.
//
//  channel  | handshake        | fields
//  ---------+------------------+---------------------------------------
//  command  | start / busy     | cmd (1 = reseed, 0 = draw), seed_value
//  result   | done (strobe)    | random_word
//
// A draw steps through its busy states in order (read the word pair, read
// the middle word, twist and temper); the word appears with done in the cycle after.
// A reseed walks the 624-word state one word a cycle through the seed
// multiplier and gives no result. A draw before any seed runs the default
// seed walk first, then the draw.
// Reset clears the controller and marks the state as never seeded; the
// state memory itself is not cleared. The receiver cannot stall: done is
// a single-cycle strobe; the word stays on random_word until the next draw replaces it.
module mersenne_twister_generator_core
    import mtg_pkg::*;
#(
    parameter int unsigned STATE_DEPTH   = DEF_STATE_DEPTH,
    parameter int unsigned MIDDLE_OFFSET = DEF_MIDDLE_OFFSET
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [31:0] seed_value,
    output logic        done,
    output logic [31:0] random_word
);

    mtg_ctrl_t   ctrl;
    mtg_status_t status;

    // Sequence the command: a seed walk, a three-step draw, or a default seed walk then the draw.
    mtg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy),
        .done   (done)
    );

    // Hold the state words and the index; twist one word per draw.
    mtg_datapath #(
        .STATE_DEPTH   (STATE_DEPTH),
        .MIDDLE_OFFSET (MIDDLE_OFFSET)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_value  (seed_value),
        .ctrl        (ctrl),
        .status      (status),
        .random_word (random_word)
    );

endmodule

// ----- rtl/core/mtg_ctrl.sv -----
// Controller: command sequencing state machine for seeding and drawing.
module mtg_ctrl
    import mtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        cmd,
    input  mtg_status_t status,
    output mtg_ctrl_t   ctrl,
    output logic        busy,
    output logic        done
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SEED      = 5'b00010,
        ST_READ_PAIR = 5'b00100,
        ST_READ_MID  = 5'b01000,
        ST_TWIST     = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        done_next  = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd)
                    begin
                        ctrl.load_seed = 1'b1;
                        pend_next      = 1'b0;
                        state_next     = ST_SEED;
                    end
                    else if (status.unseeded)
                    begin
                        // seed with the default first, then carry on with the draw
                        ctrl.load_seed   = 1'b1;
                        ctrl.use_default = 1'b1;
                        pend_next        = 1'b1;
                        state_next       = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_READ_PAIR;
                    end
                end
            end
            ST_SEED:
            begin
                ctrl.seed_step = 1'b1;
                if (status.seed_last)
                begin
                    state_next = pend_reg ? ST_READ_PAIR : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_READ_PAIR:
            begin
                ctrl.rd_pair = 1'b1;
                state_next   = ST_READ_MID;
            end
            ST_READ_MID:
            begin
                ctrl.rd_mid = 1'b1;
                state_next  = ST_TWIST;
            end
            ST_TWIST:
            begin
                ctrl.twist = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ----- rtl/core/mtg_datapath.sv -----
// Datapath: state memory, word index, seed recurrence, twist and tempering.
module mtg_datapath
    import mtg_pkg::*;
#(
    parameter int unsigned STATE_DEPTH   = DEF_STATE_DEPTH,
    parameter int unsigned MIDDLE_OFFSET = DEF_MIDDLE_OFFSET
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] seed_value,
    input  mtg_ctrl_t   ctrl,
    output mtg_status_t status,
    output logic [31:0] random_word
);

    localparam int unsigned ADDR_W = $clog2(STATE_DEPTH);
    localparam int unsigned IDX_W  = $clog2(STATE_DEPTH + 2);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] MID_SPLIT = ADDR_W'(STATE_DEPTH - MIDDLE_OFFSET);
    localparam logic [ADDR_W-1:0] MID_FWD   = ADDR_W'(MIDDLE_OFFSET);
    localparam logic [ADDR_W-1:0] MID_BACK  = ADDR_W'(STATE_DEPTH - MIDDLE_OFFSET);
    localparam logic [IDX_W-1:0]  IDX_EXH   = IDX_W'(STATE_DEPTH);
    localparam logic [IDX_W-1:0]  IDX_NEVER = IDX_W'(STATE_DEPTH + 1);

    logic [31:0] mem [STATE_DEPTH];

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [31:0]       prev_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [31:0]       y_reg;
    logic [31:0]       rd_a_reg, rd_b_reg;
    logic [31:0]       out_reg;

    logic [ADDR_W-1:0] k_sel, nxt_addr, mid_addr, addr_a, waddr;
    logic [31:0]       seed_mix, seed_prod, seed_word, twisted, wdata;
    logic              we, rd_en;

    // Current word: restart at zero once the state is used up.
    assign k_sel    = (idx_reg >= IDX_EXH) ? '0 : idx_reg[ADDR_W-1:0];
    assign nxt_addr = (k_sel == LAST_ADDR) ? '0 : k_sel + 1'b1;
    assign mid_addr = (k_reg < MID_SPLIT) ? k_reg + MID_FWD : k_reg - MID_BACK;

    assign addr_a = ctrl.rd_mid ? mid_addr : k_sel;
    assign rd_en  = ctrl.rd_pair | ctrl.rd_mid;

    assign seed_mix  = prev_reg ^ (prev_reg >> 30);
    assign seed_prod = SEED_MULT * seed_mix;
    assign seed_word = (cnt_reg == '0) ? prev_reg : seed_prod + 32'(cnt_reg);

    // Twist one word in place; words above it are still from the last round.
    assign twisted = rd_a_reg ^ (y_reg >> 1) ^ (y_reg[0] ? TWIST_XOR : 32'h0);

    assign we    = ctrl.seed_step | ctrl.twist;
    assign waddr = ctrl.seed_step ? cnt_reg : k_reg;
    assign wdata = ctrl.seed_step ? seed_word : twisted;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[nxt_addr];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (ctrl.load_seed)
        begin
            cnt_next = '0;
        end
        else if (ctrl.seed_step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_ADDR)
            begin
                idx_next = IDX_EXH;
            end
        end
        else if (ctrl.twist)
        begin
            idx_next = IDX_W'(k_reg) + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IDX_NEVER;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_seed)
        begin
            prev_reg <= ctrl.use_default ? DEFAULT_SEED : seed_value;
        end
        else if (ctrl.seed_step)
        begin
            prev_reg <= seed_word;
        end
        if (ctrl.rd_pair)
        begin
            k_reg <= k_sel;
        end
        if (ctrl.rd_mid)
        begin
            y_reg <= {rd_a_reg[31], rd_b_reg[30:0]};
        end
        if (ctrl.twist)
        begin
            out_reg <= temper(twisted);
        end
    end

    assign status.unseeded  = (idx_reg == IDX_NEVER);
    assign status.seed_last = (cnt_reg == LAST_ADDR);
    assign random_word      = out_reg;

endmodule

// ----- rtl/core/mtg_checker.sv -----
// Checker: port-level timing checks on the generator, bound to the top level.
`include "mersenne_twister_generator_core_macros.svh"

module mtg_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic done
);

    `MTG_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `MTG_ASSERT_NOW(a_done_idle, done, !busy)
    `MTG_ASSERT_NEXT(a_done_single, done, !done)
    `MTG_ASSERT_NEXT(a_no_early_word, start && !busy && !cmd, !done)

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);
